// ===== hw/rtl/csv_rs_pkg.sv =====
`timescale 1ns / 1ps

package csv_rs_pkg;

  localparam logic [7:0] NlByte    = 8'd10;
  localparam logic [7:0] QuoteByte = 8'd34;

  localparam logic [7:0]  SepReset    = 8'd44;
  localparam logic [15:0] MaxLenReset = 16'd4096;

  localparam logic CfgSeparator = 1'b0;
  localparam logic CfgMaxLength = 1'b1;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StTooLong    = 2'd1,
    StMismatch   = 2'd2,
    StUntermRec  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  chr;
    logic        is_end;
    status_e     status;
    logic [31:0] line;
    logic [15:0] len;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/csv_record_splitter_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/tready        tdata: in_char; tuser: end_of_stream
// m_axis    out        m_axis_tvalid/tready        tdata/tuser/tlast: one result each
// cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// The held byte is judged in the cycle the next item is accepted; results sit in the output
// buffer from the next cycle on, so one item per cycle is taken while the receiver takes results.
// An end-of-stream item may give two results and then holds the input until the receiver
// has taken the first of them.
// s_axis_tready follows m_axis_tready through the two-entry output buffer.
// Reset clears the held byte, the quote flag and both counters, and sets the line-start flag.
module csv_record_splitter_top
  import csv_rs_pkg::*;
#(
  parameter int LINE_COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tuser,   // [0] end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] out_char, [39:8] line_number,
                                      // [55:40] record_length
  output logic [2:0]  m_axis_tuser,   // [0] is_record_end, [2:1] status
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [LINE_COUNT_WIDTH-1:0] LineMax = '1;

  logic [7:0]                  sep_q;
  logic [15:0]                 max_len_q;
  logic [7:0]                  hchar_q, hchar_d;
  logic                        held_q, held_d;
  logic                        quoted_q, quoted_d;
  logic                        start_q, start_d;
  logic                        swallow_q, swallow_d;
  logic [LINE_COUNT_WIDTH-1:0] nl_q, nl_d;
  logic [15:0]                 len_q, len_d;

  res_t       res0_q, res1_q, res0_d, res1_d;
  logic [1:0] cnt_q, n_d;

  logic        in_acc, out_acc, eos, ended;
  logic        is_nl, is_q, la_q, la_sepnl;
  logic [63:0] nl_ext;
  logic [31:0] line_sat;

  assign eos      = s_axis_tuser;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign is_nl    = (hchar_q == NlByte);
  assign is_q     = (hchar_q == QuoteByte);
  assign la_q     = !eos && (s_axis_tdata == QuoteByte);
  assign la_sepnl = !eos && ((s_axis_tdata == sep_q) || (s_axis_tdata == NlByte));

  assign nl_d     = (held_q && !swallow_q && is_nl && (nl_q != LineMax)) ?
                    nl_q + 1'b1 : nl_q;
  assign nl_ext   = 64'(nl_d);
  assign line_sat = (nl_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nl_ext[31:0];

  always_comb begin
    hchar_d   = hchar_q;
    held_d    = held_q;
    quoted_d  = quoted_q;
    start_d   = start_q;
    swallow_d = swallow_q;
    len_d     = len_q;
    res0_d    = '0;
    res1_d    = '0;
    n_d       = 2'd0;
    ended     = 1'b0;

    if (held_q) begin
      n_d = 2'd1;
      if (!swallow_q && is_nl && !quoted_q) begin
        res0_d.is_end = 1'b1;
        res0_d.status = (len_q > max_len_q) ? StTooLong : StOk;
        res0_d.line   = line_sat;
        res0_d.len    = len_q;
        quoted_d = 1'b0;
        start_d  = 1'b1;
        len_d    = '0;
        ended    = 1'b1;
      end else begin
        len_d       = (len_q != 16'hFFFF) ? len_q + 16'd1 : len_q;
        res0_d.chr  = hchar_q;
        res0_d.line = line_sat;
        res0_d.len  = len_d;
        if (swallow_q) begin
          swallow_d = 1'b0;
        end else if (start_q && is_q) begin
          start_d  = 1'b0;
          quoted_d = 1'b1;
        end else if (is_q && la_q && quoted_q) begin
          swallow_d = 1'b1;
        end else if (is_q && la_sepnl) begin
          quoted_d = 1'b0;
        end else if ((hchar_q == sep_q) && !quoted_q) begin
          if (la_q) begin
            quoted_d  = 1'b1;
            start_d   = 1'b0;
            swallow_d = 1'b1;
          end
        end else begin
          start_d = 1'b0;
        end
      end
    end

    if (!eos) begin
      hchar_d = s_axis_tdata;
      held_d  = 1'b1;
      if (!held_q) begin
        swallow_d = 1'b0;
      end
    end else begin
      hchar_d   = '0;
      held_d    = 1'b0;
      swallow_d = 1'b0;
      if (!ended && ((len_d != 16'd0) || quoted_d)) begin
        if (held_q) begin
          res1_d.is_end = 1'b1;
          res1_d.status = quoted_d ? StMismatch : StUntermRec;
          res1_d.line   = line_sat;
          res1_d.len    = len_d;
        end else begin
          res0_d.is_end = 1'b1;
          res0_d.status = quoted_d ? StMismatch : StUntermRec;
          res0_d.line   = line_sat;
          res0_d.len    = len_d;
        end
        n_d      = n_d + 2'd1;
        quoted_d = 1'b0;
        start_d  = 1'b1;
        len_d    = '0;
      end
    end

    if (n_d == 2'd1) begin
      res0_d.last = 1'b1;
    end
    if (n_d == 2'd2) begin
      res1_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q     <= SepReset;
      max_len_q <= MaxLenReset;
      hchar_q   <= '0;
      held_q    <= 1'b0;
      quoted_q  <= 1'b0;
      start_q   <= 1'b1;
      swallow_q <= 1'b0;
      nl_q      <= '0;
      len_q     <= '0;
      cnt_q     <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgSeparator: sep_q     <= cfg_data_i[7:0];
          CfgMaxLength: max_len_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        hchar_q   <= hchar_d;
        held_q    <= held_d;
        quoted_q  <= quoted_d;
        start_q   <= start_d;
        swallow_q <= swallow_d;
        nl_q      <= nl_d;
        len_q     <= len_d;
        cnt_q     <= n_d;
      end else if (out_acc) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res0_q <= res0_d;
      res1_q <= res1_d;
    end else if (out_acc) begin
      res0_q <= res1_q;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {res0_q.len, res0_q.line, res0_q.chr};
  assign m_axis_tuser  = {res0_q.status, res0_q.is_end};
  assign m_axis_tlast  = res0_q.last;

endmodule

// ===== hw/rtl/csv_rs_checker.sv =====
`timescale 1ns / 1ps

module csv_rs_checker
  import csv_rs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("record end carries a byte");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[2:1] == StOk)
    else $error("byte item with non-ok status");

  a_byte_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[55:40] != 16'd0)
    else $error("byte item with zero record length");

endmodule

bind csv_record_splitter_top csv_rs_checker u_csv_rs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
